// ===== rtl/core/bblfu_pkg.sv =====
package bblfu_pkg;

	localparam int TableSlotsDef = 16;
	localparam int IdSpaceDef = 1024;

	localparam int OpW = 3;
	localparam int IdW = 10;
	localparam int HandleW = 64;
	localparam int SizeW = 40;
	localparam int CntW = 32;
	localparam int UsedW = 44;
	localparam int EntW = 5;

	localparam int InFieldW = IdW + HandleW + SizeW + CntW;
	localparam int InDataW = ((InFieldW + 7) / 8) * 8;
	localparam int OutFieldW = 2 + IdW + HandleW + SizeW + CntW + UsedW + EntW;
	localparam int OutDataW = ((OutFieldW + 7) / 8) * 8;

	localparam logic [OpW-1:0] OP_REGISTER = 3'd0;
	localparam logic [OpW-1:0] OP_REMOVE = 3'd1;
	localparam logic [OpW-1:0] OP_UPDATE = 3'd2;
	localparam logic [OpW-1:0] OP_QUERY = 3'd3;
	localparam logic [OpW-1:0] OP_SETCNT = 3'd4;

	typedef enum logic [2:0] {
		CELL_NOP,
		CELL_INSERT,
		CELL_UPDATE,
		CELL_DROP,
		CELL_SETCNT
	} cell_op_t;

	typedef struct packed {
		cell_op_t kind;
		logic [IdW-1:0] id;
		logic [HandleW-1:0] handle;
		logic [SizeW-1:0] size;
		logic [CntW-1:0] cnt;
	} cell_cmd_t;

	typedef struct packed {
		logic vld;
		logic [IdW-1:0] id;
		logic [HandleW-1:0] handle;
		logic [SizeW-1:0] size;
		logic [CntW-1:0] cnt;
	} cell_view_t;

	typedef struct packed {
		logic kind;
		logic succ;
		logic found;
		logic [IdW-1:0] id;
		logic [HandleW-1:0] handle;
		logic [SizeW-1:0] size;
		logic [CntW-1:0] cnt;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_REPL,
		ST_CHECK,
		ST_SCAN,
		ST_EVICT,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/core/bblfu_cell.sv =====
module bblfu_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bblfu_pkg::cell_cmd_t  cmd,
	input  logic                  ins_sel,
	input  bblfu_pkg::cell_view_t prev_tok,
	output bblfu_pkg::cell_view_t view,
	output bblfu_pkg::cell_view_t tok
);
	import bblfu_pkg::*;

	logic vld_q;
	logic [IdW-1:0] id_q;
	logic [HandleW-1:0] handle_q;
	logic [SizeW-1:0] size_q;
	logic [CntW-1:0] cnt_q;
	logic tok_vld_q;
	logic [IdW-1:0] tok_id_q;
	logic [HandleW-1:0] tok_handle_q;
	logic [SizeW-1:0] tok_size_q;
	logic [CntW-1:0] tok_cnt_q;
	logic match;
	logic better;

	assign match = vld_q && (id_q == cmd.id);
	assign view = '{vld: vld_q, id: id_q, handle: handle_q, size: size_q, cnt: cnt_q};

	// lower count wins, then larger size, then lower id
	assign better = vld_q && (!prev_tok.vld || (cnt_q < prev_tok.cnt) ||
		((cnt_q == prev_tok.cnt) && ((size_q > prev_tok.size) ||
		((size_q == prev_tok.size) && (id_q < prev_tok.id)))));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= better ? 1'b1 : prev_tok.vld;
			case (cmd.kind)
				CELL_INSERT: if (ins_sel) vld_q <= 1'b1;
				CELL_DROP: if (match) vld_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		tok_id_q <= better ? id_q : prev_tok.id;
		tok_handle_q <= better ? handle_q : prev_tok.handle;
		tok_size_q <= better ? size_q : prev_tok.size;
		tok_cnt_q <= better ? cnt_q : prev_tok.cnt;
		case (cmd.kind)
			CELL_INSERT: if (ins_sel) begin
				id_q <= cmd.id;
				handle_q <= cmd.handle;
				size_q <= cmd.size;
				cnt_q <= cmd.cnt;
			end
			CELL_UPDATE: if (match) begin
				handle_q <= cmd.handle;
				size_q <= cmd.size;
			end
			CELL_SETCNT: if (match) cnt_q <= cmd.cnt;
			default: ;
		endcase
	end

	assign tok = '{vld: tok_vld_q, id: tok_id_q, handle: tok_handle_q, size: tok_size_q,
		cnt: tok_cnt_q};

endmodule

// ===== rtl/core/bblfu_chain.sv =====
module bblfu_chain #(
	parameter int TABLE_SLOTS = bblfu_pkg::TableSlotsDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bblfu_pkg::cell_cmd_t      cmd,
	input  logic [bblfu_pkg::IdW-1:0] key_id,
	output logic                      hit,
	output bblfu_pkg::cell_view_t     hit_view,
	output bblfu_pkg::cell_view_t     tail,
	output logic                      has_free
);
	import bblfu_pkg::*;

	cell_view_t view [TABLE_SLOTS];
	cell_view_t tok [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] hit_vec;
	logic [TABLE_SLOTS-1:0] ins_sel;

	for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
		cell_view_t prev;
		if (i == 0) begin : g_head
			assign prev = '0;
		end else begin : g_link
			assign prev = tok[i-1];
		end
		bblfu_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.ins_sel  (ins_sel[i]),
			.prev_tok (prev),
			.view     (view[i]),
			.tok      (tok[i])
		);
		assign hit_vec[i] = view[i].vld && (view[i].id == key_id);
	end

	always_comb begin
		cell_view_t acc;
		logic taken;
		acc = '0;
		taken = 1'b0;
		ins_sel = '0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			acc = acc | (hit_vec[i] ? view[i] : '0);
			if (!view[i].vld && !taken) begin
				ins_sel[i] = (cmd.kind == CELL_INSERT);
				taken = 1'b1;
			end
		end
		hit_view = acc;
		has_free = taken;
	end

	assign hit = |hit_vec;
	assign tail = tok[TABLE_SLOTS-1];

	a_unique_ids: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(hit_vec))
		else $error("two resident slots share an id");
	a_insert_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.kind == CELL_INSERT) |-> has_free)
		else $error("insert with no free slot");
	a_insert_one: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(ins_sel))
		else $error("insert into more than one slot");

endmodule

// ===== rtl/core/byte_budget_lfu_residency_table_core.sv =====
// query, remove, update, set-count and a rejected register: look, then emit the answer
// register of a resident id: look, replace (report registered), then emit the answer
// register of a new id: look, check, then per eviction scan and evict, back to check; then emit
// one item at a time; next word taken once the answer is registered
// reset: table empty, budget 0; the count memory is then swept to zero over all ID_SPACE
// entries, during which no input word is taken (config writes are taken)
module byte_budget_lfu_residency_table_core #(
	parameter int TABLE_SLOTS = bblfu_pkg::TableSlotsDef,
	parameter int ID_SPACE = bblfu_pkg::IdSpaceDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input word
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// cluster_id, handle, size_bytes, use count (low to high), zero pad
	input  logic [bblfu_pkg::InDataW-1:0]  s_tdata,
	// op
	input  logic [bblfu_pkg::OpW-1:0]      s_tuser,
	// result word
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// success, found, out_cluster_id, out_handle, out_size, out_count,
	// used_total, entry_count (low to high), zero pad
	output logic [bblfu_pkg::OutDataW-1:0] m_tdata,
	// record_kind
	output logic [0:0]                     m_tuser,
	output logic                           m_tlast,
	// budget register write
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bblfu_pkg::SizeW-1:0]    cfg_data
);
	import bblfu_pkg::*;

	localparam int IdxW = $clog2(ID_SPACE);
	localparam int NW = $clog2(TABLE_SLOTS + 1);

	state_t state_q, state_d;

	// latched input word
	logic [OpW-1:0] op_q;
	logic [IdW-1:0] id_q;
	logic [HandleW-1:0] handle_q;
	logic [SizeW-1:0] size_q;
	logic [CntW-1:0] acnt_q;

	logic [SizeW-1:0] budget_q;
	logic [UsedW-1:0] used_q, used_d;
	logic [NW-1:0] n_q, n_d;
	logic [NW-1:0] scan_q;
	logic [IdxW-1:0] clr_q;

	// access count memory, one read and one write port
	logic [CntW-1:0] cnt_mem [ID_SPACE];
	logic [CntW-1:0] rd_q;
	logic mem_we;
	logic [IdxW-1:0] mem_waddr;
	logic [CntW-1:0] mem_wdata;

	result_t res_q, res_d;
	logic res_ld;

	// output register
	logic o_vld_q;
	result_t o_res_q, o_res_d;
	logic [UsedW-1:0] o_used_q, o_used_d;
	logic [EntW-1:0] o_n_q, o_n_d;
	logic o_ld;
	logic out_free;

	cell_cmd_t cmd;
	logic hit;
	cell_view_t hit_view;
	cell_view_t tail;
	logic has_free;

	logic accept;
	logic in_rng;
	logic [CntW-1:0] cof;
	logic over;
	logic full;

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !o_vld_q || m_tready;

	// ids beyond the count memory read as zero
	assign in_rng = (32'(id_q) < ID_SPACE);
	assign cof = in_rng ? rd_q : '0;
	assign over = ({1'b0, used_q} + (UsedW + 1)'(size_q)) > (UsedW + 1)'(budget_q);
	assign full = (n_q == NW'(TABLE_SLOTS));

	bblfu_chain #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.key_id   (id_q),
		.hit      (hit),
		.hit_view (hit_view),
		.tail     (tail),
		.has_free (has_free)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == IdxW'(ID_SPACE - 1)) state_d = ST_IDLE;
			ST_IDLE: if (accept) state_d = ST_LOOK;
			ST_LOOK: begin
				if (op_q == OP_REGISTER && size_q <= budget_q)
					state_d = hit ? ST_REPL : ST_CHECK;
				else
					state_d = ST_EMIT;
			end
			ST_REPL: if (out_free) state_d = ST_EMIT;
			ST_CHECK: begin
				if ((n_q != '0) && (over || full)) state_d = ST_SCAN;
				else state_d = ST_EMIT;
			end
			// wait for the min token to ripple out of the last cell
			ST_SCAN: if (scan_q == NW'(TABLE_SLOTS)) state_d = ST_EVICT;
			ST_EVICT: if (out_free) state_d = ST_CHECK;
			ST_EMIT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// actions per state
	always_comb begin
		cmd = '{kind: CELL_NOP, id: id_q, handle: handle_q, size: size_q, cnt: cof};
		used_d = used_q;
		n_d = n_q;
		res_ld = 1'b0;
		res_d = '{kind: 1'b1, succ: 1'b0, found: 1'b0, id: id_q, handle: '0, size: '0,
			cnt: cof};
		o_ld = 1'b0;
		o_res_d = res_q;
		o_used_d = used_q;
		o_n_d = EntW'(n_q);
		mem_we = 1'b0;
		mem_waddr = IdxW'(id_q);
		mem_wdata = acnt_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_LOOK: begin
				res_ld = 1'b1;
				case (op_q)
					OP_REGISTER: ; // rejected unless it moves on to replace or insert
					OP_REMOVE: if (hit) begin
						cmd.kind = CELL_DROP;
						used_d = used_q - UsedW'(hit_view.size);
						n_d = n_q - NW'(1);
						res_d.succ = 1'b1;
						res_d.found = 1'b1;
						res_d.handle = hit_view.handle;
						res_d.size = hit_view.size;
					end
					OP_UPDATE: if (hit) begin
						cmd.kind = CELL_UPDATE;
						used_d = used_q - UsedW'(hit_view.size) + UsedW'(size_q);
						res_d.succ = 1'b1;
						res_d.found = 1'b1;
						res_d.handle = handle_q;
						res_d.size = size_q;
					end
					OP_QUERY: begin
						res_d.succ = 1'b1;
						res_d.found = hit;
						res_d.handle = hit_view.handle;
						res_d.size = hit_view.size;
					end
					OP_SETCNT: begin
						res_d.found = hit;
						res_d.handle = hit_view.handle;
						res_d.size = hit_view.size;
						res_d.cnt = in_rng ? acnt_q : '0;
						res_d.succ = in_rng;
						if (in_rng) begin
							mem_we = 1'b1;
							cmd.kind = CELL_SETCNT;
							cmd.cnt = acnt_q;
						end
					end
					default: res_d.cnt = '0;
				endcase
			end
			ST_REPL: if (out_free) begin
				// report the old entry while overwriting it in place
				o_ld = 1'b1;
				o_res_d = '{kind: 1'b0, succ: 1'b1, found: 1'b1, id: id_q,
					handle: hit_view.handle, size: hit_view.size, cnt: cof};
				cmd.kind = CELL_UPDATE;
				used_d = used_q - UsedW'(hit_view.size) + UsedW'(size_q);
				res_ld = 1'b1;
				res_d.succ = 1'b1;
				res_d.found = 1'b1;
				res_d.handle = handle_q;
				res_d.size = size_q;
			end
			ST_CHECK: begin
				if (!((n_q != '0) && (over || full))) begin
					res_ld = 1'b1;
					if (!(over || full)) begin
						cmd.kind = CELL_INSERT;
						used_d = used_q + UsedW'(size_q);
						n_d = n_q + NW'(1);
						res_d.succ = 1'b1;
						res_d.handle = handle_q;
						res_d.size = size_q;
					end
				end
			end
			ST_EVICT: if (out_free) begin
				o_ld = 1'b1;
				o_res_d = '{kind: 1'b0, succ: 1'b1, found: 1'b1, id: tail.id,
					handle: tail.handle, size: tail.size, cnt: tail.cnt};
				cmd.kind = CELL_DROP;
				cmd.id = tail.id;
				used_d = used_q - UsedW'(tail.size);
				n_d = n_q - NW'(1);
				o_used_d = used_d;
				o_n_d = EntW'(n_d);
			end
			ST_EMIT: o_ld = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			scan_q <= '0;
			budget_q <= '0;
			used_q <= '0;
			n_q <= '0;
			o_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + IdxW'(1);
			scan_q <= (state_q == ST_SCAN) ? scan_q + NW'(1) : '0;
			if (cfg_valid && cfg_ready) budget_q <= cfg_data;
			used_q <= used_d;
			n_q <= n_d;
			if (o_ld) o_vld_q <= 1'b1;
			else if (m_tready) o_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= s_tuser;
			id_q <= s_tdata[IdW-1:0];
			handle_q <= s_tdata[IdW+HandleW-1:IdW];
			size_q <= s_tdata[IdW+HandleW+SizeW-1:IdW+HandleW];
			acnt_q <= s_tdata[InFieldW-1:IdW+HandleW+SizeW];
		end
		if (res_ld) res_q <= res_d;
		if (o_ld) begin
			o_res_q <= o_res_d;
			o_used_q <= o_used_d;
			o_n_q <= o_n_d;
		end
	end

	// count memory
	always_ff @(posedge clk) begin
		if (mem_we) cnt_mem[mem_waddr] <= mem_wdata;
		if (accept) rd_q <= cnt_mem[IdxW'(s_tdata[IdW-1:0])];
	end

	assign m_tvalid = o_vld_q;
	assign m_tuser = o_res_q.kind;
	assign m_tlast = o_res_q.kind;
	assign m_tdata = {{(OutDataW - OutFieldW){1'b0}}, o_n_q, o_used_q, o_res_q.cnt,
		o_res_q.size, o_res_q.handle, o_res_q.id, o_res_q.found, o_res_q.succ};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(TABLE_SLOTS))
		else $error("resident count beyond table size");
	a_victim_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVICT) |-> tail.vld)
		else $error("eviction without a victim");
	a_last_is_answer: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == m_tuser[0]))
		else $error("last flag differs from record kind");

endmodule

// ===== bench/tb_byte_budget_lfu_residency_table_core.sv =====
`timescale 1ns / 100ps

module tb_byte_budget_lfu_residency_table_core;
	import bblfu_pkg::*;

	localparam int SLOTS = TableSlotsDef;
	localparam int IDS = IdSpaceDef;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int DRAIN_CYCLES = 40;
	// op codes the block does not implement
	localparam logic [OpW-1:0] OP_UNUSED_LO = 3'd5;
	localparam logic [OpW-1:0] OP_UNUSED_HI = 3'd7;

	// one input word before packing
	typedef struct {
		logic [OpW-1:0] op;
		logic [IdW-1:0] id;
		logic [HandleW-1:0] handle;
		logic [SizeW-1:0] size;
		logic [CntW-1:0] cnt;
	} table_op_t;

	// one result word, unpacked
	typedef struct packed {
		logic kind;
		logic last;
		logic succ;
		logic found;
		logic [IdW-1:0] id;
		logic [HandleW-1:0] handle;
		logic [SizeW-1:0] size;
		logic [CntW-1:0] cnt;
		logic [UsedW-1:0] used;
		logic [EntW-1:0] ent;
	} answer_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [InDataW-1:0] s_tdata;   // cluster_id, handle, size_bytes, use count, pad
	logic [OpW-1:0] s_tuser;       // op
	logic m_tvalid;
	logic m_tready;
	logic [OutDataW-1:0] m_tdata;  // success, found, id, handle, size, count, used, entries, pad
	logic [0:0] m_tuser;           // record_kind
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [SizeW-1:0] cfg_data;

	byte_budget_lfu_residency_table_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// shadow of the residency table
	logic [SizeW-1:0] budget;
	logic shadow_valid [SLOTS];
	logic [IdW-1:0] shadow_id [SLOTS];
	logic [HandleW-1:0] shadow_handle [SLOTS];
	logic [SizeW-1:0] shadow_size [SLOTS];
	logic [UsedW-1:0] used_bytes;
	logic [CntW-1:0] freq [IDS];

	table_op_t pending_ops[$];
	answer_t expected_answers[$];
	table_op_t word_on_bus;
	int gap_left;
	int stall_left;
	bit no_idle;
	int mismatches;
	int watchdog;

	function automatic int residents();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++) if (shadow_valid[i]) n++;
		return n;
	endfunction

	function automatic int slot_of(logic [IdW-1:0] id);
		for (int i = 0; i < SLOTS; i++) if (shadow_valid[i] && shadow_id[i] == id) return i;
		return -1;
	endfunction

	// true when the new size does not fit on top of what is resident
	function automatic bit over_budget(logic [SizeW-1:0] sz);
		return ({1'b0, used_bytes} + (UsedW + 1)'(sz)) > (UsedW + 1)'(budget);
	endfunction

	task automatic expect_answer(logic kind, logic succ, logic found, logic [IdW-1:0] id,
			logic [HandleW-1:0] h, logic [SizeW-1:0] sz, logic [CntW-1:0] cnt);
		answer_t a;
		a.kind = kind;
		a.last = kind;
		a.succ = succ;
		a.found = found;
		a.id = id;
		a.handle = h;
		a.size = sz;
		a.cnt = cnt;
		a.used = used_bytes;
		a.ent = EntW'(residents());
		expected_answers = {expected_answers, a};
	endtask

	// lowest count loses, ties go to the larger size, then the lower id
	task automatic evict_lfu();
		int victim;
		victim = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (!shadow_valid[i]) continue;
			if (victim < 0 || freq[shadow_id[i]] < freq[shadow_id[victim]] ||
					(freq[shadow_id[i]] == freq[shadow_id[victim]] &&
					(shadow_size[i] > shadow_size[victim] ||
					(shadow_size[i] == shadow_size[victim] && shadow_id[i] < shadow_id[victim]))))
				victim = i;
		end
		shadow_valid[victim] = 1'b0;
		used_bytes = used_bytes - UsedW'(shadow_size[victim]);
		expect_answer(1'b0, 1'b1, 1'b1, shadow_id[victim], shadow_handle[victim],
			shadow_size[victim], freq[shadow_id[victim]]);
	endtask

	task automatic predict_table_op(table_op_t w);
		int s;
		int t;
		s = slot_of(w.id);
		case (w.op)
			OP_REGISTER: begin
				if (w.size > budget) begin
					expect_answer(1'b1, 1'b0, 1'b0, w.id, '0, '0, freq[w.id]);
				end else if (s >= 0) begin
					// in-place replacement, used total not checked against the budget
					expect_answer(1'b0, 1'b1, 1'b1, w.id, shadow_handle[s], shadow_size[s],
						freq[w.id]);
					used_bytes = used_bytes - UsedW'(shadow_size[s]) + UsedW'(w.size);
					shadow_handle[s] = w.handle;
					shadow_size[s] = w.size;
					expect_answer(1'b1, 1'b1, 1'b1, w.id, w.handle, w.size, freq[w.id]);
				end else begin
					while (residents() > 0 && (over_budget(w.size) || residents() >= SLOTS))
						evict_lfu();
					if (over_budget(w.size) || residents() >= SLOTS) begin
						expect_answer(1'b1, 1'b0, 1'b0, w.id, '0, '0, freq[w.id]);
					end else begin
						t = 0;
						while (shadow_valid[t]) t++;
						shadow_valid[t] = 1'b1;
						shadow_id[t] = w.id;
						shadow_handle[t] = w.handle;
						shadow_size[t] = w.size;
						used_bytes = used_bytes + UsedW'(w.size);
						expect_answer(1'b1, 1'b1, 1'b0, w.id, w.handle, w.size, freq[w.id]);
					end
				end
			end
			OP_REMOVE: begin
				if (s < 0) begin
					expect_answer(1'b1, 1'b0, 1'b0, w.id, '0, '0, freq[w.id]);
				end else begin
					shadow_valid[s] = 1'b0;
					used_bytes = used_bytes - UsedW'(shadow_size[s]);
					expect_answer(1'b1, 1'b1, 1'b1, w.id, shadow_handle[s], shadow_size[s],
						freq[w.id]);
				end
			end
			OP_UPDATE: begin
				if (s < 0) begin
					expect_answer(1'b1, 1'b0, 1'b0, w.id, '0, '0, freq[w.id]);
				end else begin
					used_bytes = used_bytes - UsedW'(shadow_size[s]) + UsedW'(w.size);
					shadow_handle[s] = w.handle;
					shadow_size[s] = w.size;
					expect_answer(1'b1, 1'b1, 1'b1, w.id, w.handle, w.size, freq[w.id]);
				end
			end
			OP_QUERY: begin
				if (s < 0)
					expect_answer(1'b1, 1'b1, 1'b0, w.id, '0, '0, freq[w.id]);
				else
					expect_answer(1'b1, 1'b1, 1'b1, w.id, shadow_handle[s], shadow_size[s],
						freq[w.id]);
			end
			OP_SETCNT: begin
				freq[w.id] = w.cnt;
				if (s < 0)
					expect_answer(1'b1, 1'b1, 1'b0, w.id, '0, '0, w.cnt);
				else
					expect_answer(1'b1, 1'b1, 1'b1, w.id, shadow_handle[s], shadow_size[s],
						w.cnt);
			end
			default: expect_answer(1'b1, 1'b0, 1'b0, w.id, '0, '0, '0);
		endcase
	endtask

	// driver: predicts on accept, then presents the next pending word or idles
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_table_op(word_on_bus);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0 && !no_idle) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					word_on_bus = pending_ops.pop_front();
					s_tdata <= InDataW'({word_on_bus.cnt, word_on_bus.size,
						word_on_bus.handle, word_on_bus.id});
					s_tuser <= word_on_bus.op;
					s_tvalid <= 1'b1;
					if (!no_idle && $urandom_range(0, 5) == 0)
						gap_left = $urandom_range(1, 18);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each accepted result word against the oldest expectation
	always @(posedge clk) begin
		answer_t got;
		answer_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser[0];
				got.last = m_tlast;
				got.succ = m_tdata[0];
				got.found = m_tdata[1];
				got.id = m_tdata[2 +: IdW];
				got.handle = m_tdata[12 +: HandleW];
				got.size = m_tdata[76 +: SizeW];
				got.cnt = m_tdata[116 +: CntW];
				got.used = m_tdata[148 +: UsedW];
				got.ent = m_tdata[192 +: EntW];
				if (expected_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: %p", got);
				end else begin
					want = expected_answers.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result mismatch at %0t", $realtime);
							$display("  expected %p", want);
							$display("  actual   %p", got);
						end
					end
				end
			end
			// stall bursts on the result side
			if (stall_left > 0 && !no_idle) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				watchdog <= 0;
			else
				watchdog <= watchdog + 1;
			if (watchdog >= WATCHDOG_LIMIT) begin
				$display("FAIL byte_budget_lfu_residency_table_core");
				$finish;
			end
		end
	end

	task automatic write_budget(logic [SizeW-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		budget = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_op(logic [OpW-1:0] op, logic [IdW-1:0] id,
			logic [HandleW-1:0] h, logic [SizeW-1:0] sz, logic [CntW-1:0] cnt);
		table_op_t w;
		w.op = op;
		w.id = id;
		w.handle = h;
		w.size = sz;
		w.cnt = cnt;
		pending_ops = {pending_ops, w};
	endtask

	// random mix, mostly a small id pool so that hits, ties and evictions happen
	task automatic queue_random_ops(int n);
		logic [OpW-1:0] op;
		logic [IdW-1:0] id;
		logic [63:0] wide;
		logic [SizeW-1:0] sz;
		logic [CntW-1:0] cnt;
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) op = OP_REGISTER;
			else if (pick < 60) op = OP_SETCNT;
			else if (pick < 72) op = OP_QUERY;
			else if (pick < 84) op = OP_REMOVE;
			else if (pick < 95) op = OP_UPDATE;
			else op = OpW'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
			id = ($urandom_range(0, 4) == 0) ? IdW'($urandom) : IdW'($urandom_range(0, 23));
			wide = {$urandom, $urandom};
			if ($urandom_range(0, 9) == 0)
				sz = SizeW'(wide);
			else
				sz = SizeW'(wide % ((64'(budget) / 5) + 1));
			cnt = ($urandom_range(0, 9) == 0) ? CntW'($urandom) : CntW'($urandom_range(0, 3));
			queue_op(op, id, {$urandom, $urandom}, sz, cnt);
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_ops.size() > 0 || s_tvalid || expected_answers.size() > 0);
	endtask

	initial begin
		budget = '0;
		used_bytes = '0;
		for (int i = 0; i < SLOTS; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_id[i] = '0;
			shadow_handle[i] = '0;
			shadow_size[i] = '0;
		end
		for (int i = 0; i < IDS; i++) freq[i] = '0;
		gap_left = 0;
		stall_left = 0;
		no_idle = 1'b0;
		mismatches = 0;
		watchdog = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		m_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: hits, misses, rejection, replacement, full table, mass eviction
		write_budget(40'd1000);
		queue_op(OP_QUERY, 10'd5, '0, '0, '0);
		queue_op(OP_REGISTER, 10'd5, 64'h1234, 40'd100, '0);
		queue_op(OP_REGISTER, 10'd5, '1, 40'd200, '0);
		queue_op(OP_REGISTER, 10'd6, 64'h1, 40'd1001, '0);
		queue_op(OP_REGISTER, 10'd7, 64'h2, '1, '0);
		queue_op(OP_SETCNT, 10'd5, '0, '0, '1);
		queue_op(OP_SETCNT, 10'd1023, '0, '0, 32'd2);
		queue_op(OP_QUERY, 10'd5, '0, '0, '0);
		queue_op(OP_UPDATE, 10'd5, 64'hAAAA_5555_AAAA_5555, 40'd5000, '0);
		queue_op(OP_UPDATE, 10'd9, 64'h3, 40'd3, '0);
		queue_op(OP_REMOVE, 10'd5, '0, '0, '0);
		queue_op(OP_REMOVE, 10'd5, '0, '0, '0);
		queue_op(OP_UNUSED_LO, 10'd1, '1, '1, '1);
		queue_op(OP_UNUSED_HI, 10'd0, '0, '0, '0);
		// fill all slots with small entries, equal counts tie on size then id
		for (int i = 0; i < 17; i++)
			queue_op(OP_REGISTER, IdW'(i), 64'(i), 40'(i % 3), '0);
		// one entry as big as the budget evicts every entry of nonzero size
		queue_op(OP_REGISTER, 10'd1023, '1, 40'd1000, '0);
		queue_op(OP_REGISTER, 10'd0, '0, '0, '0);
		wait_idle();

		write_budget('0);
		queue_random_ops(40);
		wait_idle();

		write_budget('1);
		queue_random_ops(80);
		wait_idle();

		write_budget(40'd3000);
		queue_random_ops(90);
		wait_idle();

		// last part runs at full rate on both sides
		write_budget(SizeW'($urandom_range(500, 20000)));
		no_idle = 1'b1;
		queue_random_ops(90);
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_answers.size() == 0)
			$display("PASS byte_budget_lfu_residency_table_core");
		else
			$display("FAIL byte_budget_lfu_residency_table_core");
		$finish;
	end

endmodule
